FILE: hw/rtl/b58_pkg.sv
// Shared types, constants and the alphabet lookup for the base58 encoder.
// No dependencies; every other file refers to it by scoped names.
package b58_pkg;

  localparam int unsigned WordW     = 64;
  localparam int unsigned ValueW    = 4 * WordW;
  localparam int unsigned DigitW    = 6;
  localparam int unsigned SymW      = 7;
  localparam int unsigned Radix     = 58;

  // Long division works on one chunk of the value per cycle while it runs.
  localparam int unsigned ChunkW    = 16;
  localparam int unsigned NumChunks = ValueW / ChunkW;
  localparam int unsigned StepW     = $clog2(NumChunks);
  localparam int unsigned AccW      = DigitW + ChunkW;

  // q = (acc * RecipMul) >> RecipShift is exact for every acc < 2**AccW:
  // RecipMul * Radix - 2**RecipShift = 28 <= 2**(RecipShift - AccW) = 64.
  localparam int unsigned RecipShift = 28;
  localparam int unsigned RecipW     = 23;
  localparam logic [RecipW-1:0] RecipMul = 23'd4628198;
  localparam int unsigned ProdW      = AccW + RecipW;

  typedef struct packed {
    logic [WordW-1:0] value_word_0;
    logic [WordW-1:0] value_word_1;
    logic [WordW-1:0] value_word_2;
    logic [WordW-1:0] value_word_3;
  } in_item_t;

  typedef struct packed {
    logic [SymW-1:0]   symbol;
    logic [DigitW-1:0] digit_value;
    logic              last_symbol;
  } out_item_t;

  typedef struct packed {
    logic              last;     // current step closes a division pass
    logic              nonzero;  // quotient of this pass is not zero
    logic [DigitW-1:0] digit;    // remainder, valid on the closing step
  } div_status_t;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StRead,
    StOut
  } state_e;

  // Map a digit to its character in the base58 alphabet.
  function automatic logic [SymW-1:0] symbol_of(input logic [DigitW-1:0] d);
    logic [SymW-1:0] dx;
    logic [SymW-1:0] sym;
    dx = SymW'(d);
    if (d < 6'd9) begin
      sym = 7'd49 + dx;            // '1'..'9'
    end else if (d < 6'd17) begin
      sym = 7'd65 + dx - 7'd9;     // 'A'..'H'
    end else if (d < 6'd22) begin
      sym = 7'd74 + dx - 7'd17;    // 'J'..'N'
    end else if (d < 6'd33) begin
      sym = 7'd80 + dx - 7'd22;    // 'P'..'Z'
    end else if (d < 6'd44) begin
      sym = 7'd97 + dx - 7'd33;    // 'a'..'k'
    end else if (d < 6'd58) begin
      sym = 7'd109 + dx - 7'd44;   // 'm'..'z'
    end else begin
      sym = '0;
    end
    return sym;
  endfunction

endpackage

FILE: hw/rtl/base58_encode_from_integer.sv
// Top level of the base58 encoder: sequencer, digit count and output stage.
// Depends on b58_pkg, b58_divider and b58_digit_mem.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_item_i) takes one 256-bit
//   unsigned value as four 64-bit words. Output channel (out_valid_o /
//   out_ready_i / out_item_o) returns one item per base58 digit, most
//   significant first, with last_symbol set on the final one. A zero value
//   produces no output item at all.
//   Leading zero bytes are not turned into '1' characters.
// Operation:
//   Each digit costs one full pass of the shared divide-by-58 unit over the
//   value, one 16-bit chunk per cycle. After the division each output item
//   takes a digit store read, then an output hold. The largest 256-bit value
//   gives 44 digits. in_ready_o is high only while the block is idle.
// Reset:
//   rst_ni clears the sequencer and counters; the digit store is not
//   cleared, since every entry read back was written for the same item.
// Stalls:
//   While out_ready_i is low the current output item holds unchanged.
module base58_encode_from_integer #(
  parameter int unsigned MAX_DIGITS = 44
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  b58_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output b58_pkg::out_item_t  out_item_o
);

  localparam int unsigned AddrW = $clog2(MAX_DIGITS);
  localparam int unsigned CntW  = $clog2(MAX_DIGITS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_DIGITS);

  b58_pkg::state_e state_q, state_d;
  logic [AddrW-1:0] cnt_q, cnt_d;        // digits stored so far this item
  logic [AddrW-1:0] rd_idx_q, rd_idx_d;  // digit being sent out

  logic                       value_nz;
  logic [b58_pkg::ValueW-1:0] value;
  logic                       load;
  logic                       run;
  b58_pkg::div_status_t       div_st;
  logic                       mem_we;
  logic [b58_pkg::DigitW-1:0] rd_digit;
  logic [CntW-1:0]            cnt_next;

  assign value = {in_item_i.value_word_3, in_item_i.value_word_2,
                  in_item_i.value_word_1, in_item_i.value_word_0};
  assign value_nz = (value != '0);
  assign cnt_next = CntW'(cnt_q) + 1'b1;

  b58_divider u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .value_i  (value),
    .run_i    (run),
    .status_o (div_st)
  );

  b58_digit_mem #(
    .Depth (MAX_DIGITS),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q),
    .wdata_i (div_st.digit),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_digit)
  );

  // Next state and handshake outputs.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    load        = 1'b0;
    run         = 1'b0;
    mem_we      = 1'b0;
    case (state_q)
      b58_pkg::StIdle: begin
        in_ready_o = 1'b1;
        // Accept the item; drop it right away when the value is zero.
        if (in_valid_i && value_nz) begin
          load    = 1'b1;
          cnt_d   = '0;
          state_d = b58_pkg::StDiv;
        end
      end
      b58_pkg::StDiv: begin
        run = 1'b1;
        if (div_st.last) begin
          // Store the remainder of this pass as the next digit.
          mem_we = 1'b1;
          if (div_st.nonzero && (cnt_next < MaxCnt)) begin
            cnt_d = cnt_next[AddrW-1:0];
          end else begin
            rd_idx_d = cnt_q;
            state_d  = b58_pkg::StRead;
          end
        end
      end
      b58_pkg::StRead: begin
        state_d = b58_pkg::StOut;
      end
      b58_pkg::StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (rd_idx_q == '0) begin
            state_d = b58_pkg::StIdle;
          end else begin
            rd_idx_d = rd_idx_q - 1'b1;
            state_d  = b58_pkg::StRead;
          end
        end
      end
      default: begin
        state_d = b58_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= b58_pkg::StIdle;
      cnt_q    <= '0;
      rd_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  // Read data and index hold steady while an output item waits.
  assign out_item_o.digit_value = rd_digit;
  assign out_item_o.symbol      = b58_pkg::symbol_of(rd_digit);
  assign out_item_o.last_symbol = (rd_idx_q == '0);

endmodule

FILE: hw/rtl/b58_divider.sv
// Iterative divide by 58 of a 256-bit value, one 16-bit chunk per cycle of run_i.
// Depends on b58_pkg.
module b58_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic [b58_pkg::ValueW-1:0]   value_i,
  input  logic                         run_i,
  output b58_pkg::div_status_t         status_o
);

  logic [b58_pkg::ValueW-1:0] work_q, work_d;
  logic [b58_pkg::DigitW-1:0] rem_q, rem_d;
  logic [b58_pkg::StepW-1:0]  step_q, step_d;
  logic                       nz_q, nz_d;

  logic [b58_pkg::AccW-1:0]   acc;
  logic [b58_pkg::ProdW-1:0]  prod;
  logic [b58_pkg::ChunkW-1:0] quot;
  logic [b58_pkg::AccW-1:0]   quot_x;
  logic [b58_pkg::AccW-1:0]   rem_full;
  logic                       last_step;

  // Remainder of the previous chunk sits above the next chunk, as in long division.
  assign acc      = {rem_q, work_q[b58_pkg::ValueW-1 -: b58_pkg::ChunkW]};
  assign prod     = b58_pkg::ProdW'(acc) * b58_pkg::ProdW'(b58_pkg::RecipMul);
  assign quot     = prod[b58_pkg::RecipShift +: b58_pkg::ChunkW];
  assign quot_x   = b58_pkg::AccW'(quot) * b58_pkg::AccW'(b58_pkg::Radix);
  assign rem_full = acc - quot_x;

  assign last_step = (step_q == b58_pkg::StepW'(b58_pkg::NumChunks - 1));

  assign status_o.last    = last_step;
  assign status_o.nonzero = nz_q | (quot != '0);
  assign status_o.digit   = rem_full[b58_pkg::DigitW-1:0];

  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    step_d = step_q;
    nz_d   = nz_q;
    if (load_i) begin
      work_d = value_i;
      rem_d  = '0;
      step_d = '0;
      nz_d   = 1'b0;
    end else if (run_i) begin
      // Rotate the quotient chunk in at the bottom; after a full pass the
      // register holds the whole quotient in place.
      work_d = {work_q[b58_pkg::ValueW-b58_pkg::ChunkW-1:0], quot};
      if (last_step) begin
        rem_d  = '0;
        step_d = '0;
        nz_d   = 1'b0;
      end else begin
        rem_d  = rem_full[b58_pkg::DigitW-1:0];
        step_d = step_q + 1'b1;
        nz_d   = nz_q | (quot != '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      step_q <= '0;
      nz_q   <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      step_q <= step_d;
      nz_q   <= nz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

endmodule

FILE: hw/rtl/b58_digit_mem.sv
// Digit store: one write port, one registered read port.
// Depends on b58_pkg for the digit width.
module b58_digit_mem #(
  parameter int unsigned Depth = 44,
  parameter int unsigned AddrW = 6
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AddrW-1:0]            waddr_i,
  input  logic [b58_pkg::DigitW-1:0]  wdata_i,
  input  logic [AddrW-1:0]            raddr_i,
  output logic [b58_pkg::DigitW-1:0]  rdata_o
);

  logic [b58_pkg::DigitW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/b58_checker.sv
// Port-level checks for the base58 encoder, bound to the top level.
// Depends on b58_pkg and base58_encode_from_integer.
module b58_port_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input b58_pkg::out_item_t out_item_o
);

  // Hold a stalled output item unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed while stalled");

  // Never take a new item while results are still going out.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while an output item is pending");

  // Division takes time: no output right after an accepted item.
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("output item right after input accept");

  // The final character ends the encoding.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_item_o.last_symbol |=> !out_valid_o && in_ready_o)
    else $error("output continued after last symbol");

  // Every character lies in the alphabet's code range.
  a_sym_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.symbol >= 7'd49) && (out_item_o.symbol <= 7'd122))
    else $error("symbol outside base58 alphabet");

endmodule

bind base58_encode_from_integer b58_port_checker u_b58_checker (.*);

FILE: bench/b58_checker.sv
// Scoreboard for the base58 encoder: recomputes the digit string of every value
// taken in and compares each character that comes out. Depends on b58_pkg.
module b58_checker #(
  parameter int unsigned MaxDigits = 44
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  b58_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  b58_pkg::out_item_t out_item_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Digit 0 sits in the top byte.
  localparam logic [58*8-1:0] Alphabet =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  b58_pkg::out_item_t expected_chars[$];

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [b58_pkg::ValueW-1:0] rest;
    int                         digits[$];
    b58_pkg::out_item_t         want;
    b58_pkg::out_item_t         got;
    int                         errs;
    int                         d;
    if (!rst_ni) begin
      expected_chars.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      errs = 0;
      if (out_valid_i && out_ready_i) begin
        got = out_item_i;
        if (expected_chars.size() == 0) begin
          $error("unexpected character: symbol %0d digit %0d last %0b",
                 got.symbol, got.digit_value, got.last_symbol);
          errs++;
        end else begin
          want = expected_chars.pop_front();
          if (got.symbol !== want.symbol) begin
            $error("symbol: expected %0d, got %0d", want.symbol, got.symbol);
            errs++;
          end
          if (got.digit_value !== want.digit_value) begin
            $error("digit_value: expected %0d, got %0d", want.digit_value, got.digit_value);
            errs++;
          end
          if (got.last_symbol !== want.last_symbol) begin
            $error("last_symbol: expected %0b, got %0b", want.last_symbol, got.last_symbol);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        // Peel off remainders of 58, most significant digit ends up in front.
        rest = {in_item_i.value_word_3, in_item_i.value_word_2,
                in_item_i.value_word_1, in_item_i.value_word_0};
        digits.delete();
        while (rest != '0 && digits.size() < MaxDigits) begin
          digits.push_front(int'(rest % b58_pkg::Radix));
          rest = rest / b58_pkg::Radix;
        end
        foreach (digits[k]) begin
          d                = digits[k];
          want.symbol      = b58_pkg::SymW'(Alphabet[(57 - d) * 8 +: 8]);
          want.digit_value = b58_pkg::DigitW'(d);
          want.last_symbol = (k == digits.size() - 1);
          expected_chars.push_back(want);
        end
      end
      fail_count_o <= fail_count_o + errs;
      pending_o    <= expected_chars.size();
    end
  end

endmodule

FILE: bench/tb.sv
// Top of the base58 encoder bench: clock, reset, value stimulus and output back-pressure.
// Depends on b58_pkg, base58_encode_from_integer and b58_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxDigits      = 44;
  localparam int unsigned RandomValues   = 400;
  // Stall the output once for a long stretch so the encoder backs up into its input.
  localparam int unsigned HoldAtChar     = 60;
  localparam int unsigned LongHoldCycles = 400;
  // Zero values are dropped on acceptance; this is ample for any stray output to show up.
  localparam int unsigned DrainCycles    = 40;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  b58_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_ready;
  b58_pkg::out_item_t out_item;

  int fail_count;
  int pending_chars;
  int values_sent;
  int zero_values;
  int chars_taken;

  base58_encode_from_integer #(
    .MAX_DIGITS(MaxDigits)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  b58_checker #(
    .MaxDigits(MaxDigits)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .fail_count_o(fail_count),
    .pending_o   (pending_chars)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer one value after an idle gap and hold it until the encoder takes it.
  // Leave valid high afterwards so a zero gap on the next call runs back to back.
  task automatic offer_value(input logic [b58_pkg::ValueW-1:0] value,
                             input int unsigned gap);
    b58_pkg::in_item_t item;
    item.value_word_0 = value[63:0];
    item.value_word_1 = value[127:64];
    item.value_word_2 = value[191:128];
    item.value_word_3 = value[255:192];
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
    values_sent++;
    if (value == '0) zero_values++;
  endtask

  // Drop valid and sit until every predicted character has come back.
  // Step the clock before the first check so the checker's count includes the last item.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_chars != 0);
  endtask

  // 58 raised to the given power, at full value width.
  function automatic logic [b58_pkg::ValueW-1:0] power_of_58(input int unsigned k);
    logic [b58_pkg::ValueW-1:0] p;
    p = 1;
    repeat (k) p = p * b58_pkg::Radix;
    return p;
  endfunction

  initial begin : stimulus
    logic [b58_pkg::ValueW-1:0] directed[$];
    logic [b58_pkg::ValueW-1:0] value;
    int unsigned                sel;
    int unsigned                width;
    int unsigned                gap;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    values_sent = 0;
    zero_values = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed values: zero, single-digit edges, the 58 and 58^2 boundaries, each word
    // alone, the all-ones maximum (44 digits), 58^43 and one below it, lone bits 64 and
    // 255, alternating patterns, and small values whose upper bytes are all zero.
    directed = '{
      '0, 1, 2, 57, 58, 59, 3363, 3364,
      {{192{1'b0}}, {64{1'b1}}},
      {{128{1'b0}}, {64{1'b1}}, {64{1'b0}}},
      {{64{1'b0}}, {64{1'b1}}, {128{1'b0}}},
      {{64{1'b1}}, {192{1'b0}}},
      {{191{1'b0}}, 1'b1, {64{1'b0}}},
      {b58_pkg::ValueW{1'b1}},
      {1'b1, {255{1'b0}}},
      {64{4'hA}},
      {64{4'h5}},
      power_of_58(43),
      power_of_58(43) - 1,
      256'h1234
    };
    foreach (directed[i]) begin
      offer_value(directed[i], $urandom_range(0, 6));
    end
    // Let the encoder go completely quiet before the random phase.
    wait_drained();

    for (int unsigned i = 0; i < RandomValues; i++) begin
      sel = $urandom_range(0, 15);
      value = {$urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
      if (sel == 0) begin
        value = '0;
      end else if (sel <= 2) begin
        // Land just around a power of 58, where the digit count steps.
        value = power_of_58($urandom_range(1, 43)) + $urandom_range(0, 4) - 2;
      end else if (sel >= 7) begin
        // Trim to a random bit length to spread the digit count.
        width = $urandom_range(1, b58_pkg::ValueW);
        value &= {b58_pkg::ValueW{1'b1}} >> (b58_pkg::ValueW - width);
      end
      // Send one window back to back, and pause mid-run for a full drain.
      gap = (i >= 120 && i < 170) ? 0 : $urandom_range(0, 6);
      if (i == 200) wait_drained();
      offer_value(value, gap);
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("Encoded %0d values (%0d zero) into %0d base58 characters,", values_sent,
             zero_values, chars_taken);
    $display("covering the 256-bit extremes, digit-count steps and long output stalls.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Take characters with a random hold-off before each one, windows with no
  // hold-off at all, and one long stall while the sender keeps offering.
  initial begin : receiver
    int unsigned hold;
    out_ready <= 1'b0;
    chars_taken = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    hold = $urandom_range(0, 6);
    forever begin
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      chars_taken++;
      if (chars_taken == HoldAtChar) begin
        hold = LongHoldCycles;
      end else if ((chars_taken / 300) % 3 == 1) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 6);
      end
    end
  end

  // Give up with an error if the run hangs.
  initial begin : watchdog
    #20_000_000;
    $error("run timed out with %0d characters still expected", pending_chars);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: base58_encode_from_integer.f
hw/rtl/b58_pkg.sv
hw/rtl/b58_divider.sv
hw/rtl/b58_digit_mem.sv
hw/rtl/base58_encode_from_integer.sv
hw/rtl/b58_checker.sv
bench/b58_checker.sv
bench/tb.sv
